// ===== src/joystick_command_packetizer_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef JOYSTICK_COMMAND_PACKETIZER_UNIT_ASSERT_SVH
`define JOYSTICK_COMMAND_PACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define JCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jcp assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define JCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jcp assertion failed");

`endif

// ===== src/jcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jcp_pkg;

  localparam int STICK_W    = 11;
  localparam int BTN_W      = 16;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 10;
  localparam int SPEED_W    = 4;
  localparam int BYTE_W     = 8;
  localparam int VEL_W      = 20;
  localparam int YAW_W      = 21;
  localparam int SM_W       = 22;
  localparam int Q_W        = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEAD_ZONE_DEF       = 30;
  localparam int AXIS_FULL_SCALE_DEF = 512;

  localparam int VEL_FULL_MM   = 500;
  localparam int YAW_FULL_MRAD = 2000;
  localparam int Q8_SHIFT      = 8;

  // trunc(x / 5) by reciprocal, exact for |x| < 2**(SM_W-1)
  localparam int              DIV5_SHIFT = SM_W + 2;
  localparam int              DIV5_MUL_W = 22;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL =
    DIV5_MUL_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

  localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIT_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_MASK   = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 10'd10;
  localparam logic [BTN_W-1:0]    WALK_MASK_RST  = 16'h0010;
  localparam logic [BTN_W-1:0]    SPEED_MASK_RST = 16'h0020;
  localparam logic [BTN_W-1:0]    SIT_MASK_RST   = 16'h0001;
  localparam logic [BTN_W-1:0]    MODE_MASK_RST  = 16'h0008;
  localparam logic [SPEED_W-1:0]  SPEED_RST      = 4'd5;
  localparam logic [SPEED_W-1:0]  SPEED_STEP     = 4'd2;
  localparam logic [SPEED_W-1:0]  SPEED_MAX      = 4'd10;
  localparam logic [SPEED_W-1:0]  SPEED_WRAP     = 4'd2;

  localparam logic [BYTE_W-1:0] START_MARK = 8'hAA;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'h55;

  localparam int PKT_BYTES = 9;
  localparam int PKT_W     = PKT_BYTES * BYTE_W;
  localparam int CNT_W     = $clog2(PKT_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PKT_BYTES - 1);

  typedef struct packed {
    logic signed [SM_W-1:0] tv;
    logic signed [SM_W-1:0] ty;
    logic [BTN_W-1:0]       buttons;
    logic                   connected;
    logic [TIME_W-1:0]      time_ms;
  } sample_t;

  // speed_tenths * 255 / 10, truncated to a byte
  function automatic logic [BYTE_W-1:0] speed_byte(input logic [SPEED_W-1:0] v);
    logic [BYTE_W-1:0] r;
    case (v)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd25;
      4'd2:    r = 8'd51;
      4'd3:    r = 8'd76;
      4'd4:    r = 8'd102;
      4'd5:    r = 8'd127;
      4'd6:    r = 8'd153;
      4'd7:    r = 8'd178;
      4'd8:    r = 8'd204;
      4'd9:    r = 8'd229;
      4'd10:   r = 8'd255;
      4'd11:   r = 8'd24;
      4'd12:   r = 8'd50;
      4'd13:   r = 8'd75;
      4'd14:   r = 8'd101;
      default: r = 8'd126;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/joystick_command_packetizer_unit.sv =====
// Joystick command packetizer.
// Input channel (in_valid_i/in_ready_o): one controller sample per beat.
// Output channel (out_valid_o/out_ready_i): packet bytes, one per beat, nine per
// packet: 0xAA, velocity hi/lo, yaw hi/lo, flags, speed, XOR check, 0x55
// (packet_last_o on the end marker). Samples inside the send period give no bytes.
// Config port: cfg_we_i writes cfg_data_i to register cfg_index_i;
// write only while idle.
// Pipeline: the sample is scaled into the input register, then smoothed,
// decoded and framed into a 72-bit shift register that drives the output.
// The sample passes the input register and then the packet shift register before
// its first byte is valid; the rest follow one per cycle without stall.
// Non-sending samples pass on without waiting; a sending sample is held by the
// byte-wide packet shift register until the previous packet has gone.
// Stall: the packet holds its byte; a sending sample waits in the input register,
// with in_ready_o low, until the last byte of the previous packet goes.
// Reset: registers at their defaults, smoothed values and flags zero, speed
// five, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module joystick_command_packetizer_unit #(
  parameter int DEAD_ZONE       = jcp_pkg::DEAD_ZONE_DEF,
  parameter int AXIS_FULL_SCALE = jcp_pkg::AXIS_FULL_SCALE_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [jcp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [jcp_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic signed [jcp_pkg::STICK_W-1:0]    stick_forward_i,
  input  wire logic signed [jcp_pkg::STICK_W-1:0]    stick_turn_i,
  input  wire logic [jcp_pkg::BTN_W-1:0]             button_word_i,
  input  wire logic                                  pad_connected_i,
  input  wire logic [jcp_pkg::TIME_W-1:0]            time_ms_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [jcp_pkg::BYTE_W-1:0]                 packet_byte_o,
  output logic                                       packet_last_o
);
  import jcp_pkg::*;

  localparam int SPAN    = AXIS_FULL_SCALE - DEAD_ZONE;
  localparam int SPAN_W  = $clog2(SPAN + 1);
  localparam int SHIFT   = STICK_W + SPAN_W;
  localparam logic [63:0] K_VEL =
    ((64'(VEL_FULL_MM) << (Q8_SHIFT + SHIFT)) + 64'(SPAN) - 64'd1) / 64'(SPAN);
  localparam logic [63:0] K_YAW =
    ((64'(YAW_FULL_MRAD) << (Q8_SHIFT + SHIFT)) + 64'(SPAN) - 64'd1) / 64'(SPAN);
  localparam int K_W     = $clog2(K_YAW + 64'd1);
  localparam int PROD_W  = STICK_W + K_W;
  localparam int CMP_W   = 17;

  // deadzone, clamp and scale to Q8 magnitude: floor(n * full * 256 / span)
  function automatic logic [Q_W-1:0] axis_mag(input logic [STICK_W-1:0] raw,
                                               input logic [K_W-1:0]     k);
    logic [STICK_W-1:0] mag;
    logic [STICK_W-1:0] nm;
    logic [STICK_W-1:0] nmc;
    logic [PROD_W-1:0]  prod;
    mag = raw[STICK_W-1] ? (~raw + STICK_W'(1)) : raw;
    nm  = mag - STICK_W'(DEAD_ZONE);
    nmc = (CMP_W'(nm) > CMP_W'(SPAN)) ? STICK_W'(SPAN) : nm;
    prod = PROD_W'(nmc) * PROD_W'(k);
    if (CMP_W'(mag) < CMP_W'(DEAD_ZONE)) begin
      return '0;
    end
    return Q_W'(prod >> SHIFT);
  endfunction

  function automatic logic signed [SM_W-1:0] div5_trunc(input logic signed [SM_W-1:0] d);
    logic [SM_W-2:0]              mag;
    logic [SM_W-1+DIV5_MUL_W-1:0] prod;
    logic [SM_W-1:0]              q;
    mag  = (SM_W-1)'(d[SM_W-1] ? -d : d);
    prod = (SM_W-1+DIV5_MUL_W)'(mag) * (SM_W-1+DIV5_MUL_W)'(DIV5_MUL);
    q    = SM_W'(prod >> DIV5_SHIFT);
    return d[SM_W-1] ? signed'(-q) : signed'(q);
  endfunction

  function automatic logic [2*BYTE_W-1:0] q8_word(input logic signed [SM_W-1:0] s);
    logic signed [SM_W-1:0] adj;
    logic signed [SM_W-1:0] sh;
    adj = s + (s[SM_W-1] ? SM_W'(255) : SM_W'(0));
    sh  = adj >>> Q8_SHIFT;
    return sh[2*BYTE_W-1:0];
  endfunction

  logic [PERIOD_W-1:0] period_q;
  logic [BTN_W-1:0]    walk_mask_q, speed_mask_q, sit_mask_q, mode_mask_q;

  logic                     a_v_q;
  sample_t                  a_q, a_d;
  logic signed [VEL_W-1:0]  vel_q, vel_d;
  logic signed [YAW_W-1:0]  yaw_q, yaw_d;
  logic                     walk_q, walk_d, lqr_q, lqr_d, sit;
  logic [SPEED_W-1:0]       speed_q, speed_d, speed_inc;
  logic [BTN_W-1:0]         prev_q, prev_d;
  logic [TIME_W-1:0]        last_send_q, elapsed;

  logic                pk_v_q;
  logic [PKT_W-1:0]    pk_q, pk_d;
  logic [CNT_W-1:0]    cnt_q;

  logic [Q_W-1:0]          fwd_mag, turn_mag;
  logic signed [SM_W-1:0]  vel_ext, yaw_ext, vel_new, yaw_new, vel_pkt, yaw_pkt;
  logic [2*BYTE_W-1:0]     vel_word, yaw_word;
  logic [BYTE_W-1:0]       flags_b, speed_b, chk_b;
  logic                    send, out_done, a_adv, in_accept;

  always_comb begin
    fwd_mag  = axis_mag(stick_forward_i, K_W'(K_VEL));
    turn_mag = axis_mag(stick_turn_i, K_W'(K_YAW));
    a_d.tv        = stick_forward_i[STICK_W-1] ? signed'(SM_W'(fwd_mag))
                                               : signed'(-SM_W'(fwd_mag));
    a_d.ty        = stick_turn_i[STICK_W-1] ? signed'(-SM_W'(turn_mag))
                                            : signed'(SM_W'(turn_mag));
    a_d.buttons   = button_word_i;
    a_d.connected = pad_connected_i;
    a_d.time_ms   = time_ms_i;
  end

  always_comb begin
    elapsed  = a_q.time_ms - last_send_q;
    send     = elapsed >= TIME_W'(period_q);
    out_done = pk_v_q && out_ready_i && (cnt_q == LAST_IDX);
    a_adv    = a_v_q && (!send || !pk_v_q || out_done);
  end

  assign in_ready_o = !a_v_q || a_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    vel_ext = {{(SM_W-VEL_W){vel_q[VEL_W-1]}}, vel_q};
    yaw_ext = {{(SM_W-YAW_W){yaw_q[YAW_W-1]}}, yaw_q};
    vel_new = vel_ext + div5_trunc(a_q.tv - vel_ext);
    yaw_new = yaw_ext + div5_trunc(a_q.ty - yaw_ext);
    vel_pkt = a_q.connected ? vel_new : '0;
    yaw_pkt = a_q.connected ? yaw_new : '0;
    vel_d   = VEL_W'(vel_pkt);
    yaw_d   = YAW_W'(yaw_pkt);

    walk_d  = walk_q;
    lqr_d   = lqr_q;
    speed_d = speed_q;
    prev_d  = prev_q;
    sit     = 1'b0;
    speed_inc = speed_q + SPEED_STEP;
    if (a_q.connected) begin
      walk_d = |(a_q.buttons & walk_mask_q);
      if (|(a_q.buttons & speed_mask_q) && !(|(prev_q & speed_mask_q))) begin
        speed_d = (speed_inc > SPEED_MAX) ? SPEED_WRAP : speed_inc;
      end
      sit = |(a_q.buttons & sit_mask_q) && !(|(prev_q & sit_mask_q));
      if (|(a_q.buttons & mode_mask_q) && !(|(prev_q & mode_mask_q))) begin
        lqr_d = !lqr_q;
      end
      prev_d = a_q.buttons;
    end

    vel_word = q8_word(vel_pkt);
    yaw_word = q8_word(yaw_pkt);
    flags_b  = {5'd0, lqr_d, sit, walk_d};
    speed_b  = speed_byte(speed_d);
    chk_b    = vel_word[15:8] ^ vel_word[7:0] ^ yaw_word[15:8] ^ yaw_word[7:0]
             ^ flags_b ^ speed_b;
    pk_d     = {START_MARK, vel_word, yaw_word, flags_b, speed_b, chk_b, END_MARK};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RST;
      walk_mask_q  <= WALK_MASK_RST;
      speed_mask_q <= SPEED_MASK_RST;
      sit_mask_q   <= SIT_MASK_RST;
      mode_mask_q  <= MODE_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEND_PERIOD: period_q     <= cfg_data_i[PERIOD_W-1:0];
        CFG_WALK_MASK:   walk_mask_q  <= cfg_data_i;
        CFG_SPEED_MASK:  speed_mask_q <= cfg_data_i;
        CFG_SIT_MASK:    sit_mask_q   <= cfg_data_i;
        CFG_MODE_MASK:   mode_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      vel_q       <= '0;
      yaw_q       <= '0;
      walk_q      <= 1'b0;
      lqr_q       <= 1'b0;
      speed_q     <= SPEED_RST;
      prev_q      <= '0;
      last_send_q <= '0;
    end else begin
      if (in_accept) begin
        a_v_q <= 1'b1;
      end else if (a_adv) begin
        a_v_q <= 1'b0;
      end
      if (a_adv) begin
        vel_q   <= vel_d;
        yaw_q   <= yaw_d;
        walk_q  <= walk_d;
        lqr_q   <= lqr_d;
        speed_q <= speed_d;
        prev_q  <= prev_d;
        if (send) begin
          last_send_q <= a_q.time_ms;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_v_q <= 1'b0;
      cnt_q  <= '0;
    end else if (a_adv && send) begin
      pk_v_q <= 1'b1;
      cnt_q  <= '0;
    end else if (out_done) begin
      pk_v_q <= 1'b0;
    end else if (pk_v_q && out_ready_i) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && send) begin
      pk_q <= pk_d;
    end else if (pk_v_q && out_ready_i) begin
      pk_q <= {pk_q[PKT_W-BYTE_W-1:0], BYTE_W'(0)};
    end
  end

  assign out_valid_o   = pk_v_q;
  assign packet_byte_o = pk_q[PKT_W-1 -: BYTE_W];
  assign packet_last_o = (cnt_q == LAST_IDX);

endmodule

`default_nettype wire

// ===== src/jcp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "joystick_command_packetizer_unit_assert.svh"

module jcp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] packet_byte_o,
  input wire logic       packet_last_o
);

  // stalled beat holds
  `JCP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(packet_byte_o) && $stable(packet_last_o))

  `JCP_ASSERT_IMPL(a_last_is_end, out_valid_o && packet_last_o, packet_byte_o == 8'h55)

  // a packet always opens with the start mark
  `JCP_ASSERT_NEXT(a_first_is_start, !out_valid_o || (out_ready_i && packet_last_o), !out_valid_o || packet_byte_o == 8'hAA)

  `JCP_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o)

endmodule

bind joystick_command_packetizer_unit jcp_checker u_jcp_checker (.*);

`default_nettype wire
